// File: design/assert_macros.svh
// Assertion macros used by apa_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check
`define AP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define AP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/apa_pkg.sv
// Shared types and constants of the aging pool allocator.
// No dependencies; used by the core and the divider.
package apa_pkg;

  localparam int POOL_SLOTS = 64;
  localparam int SLOT_W     = 6;
  localparam int CNT_W      = 7;
  localparam int TS_W       = 31;
  localparam int CFG_IDX_W  = 2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TS_W-1:0]   ts_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE     = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_SWEEP = 1'b1;

  // Energy fade: level = 450 - ceil(3*age/20); below 255 only for age > 1300,
  // zero from age 2994 on.
  localparam logic [8:0]  ENERGY_BASE   = 9'd450;
  localparam logic [31:0] ENERGY_AGE_LO = 32'd1300;
  localparam logic [31:0] ENERGY_AGE_HI = 32'd2994;
  localparam logic [15:0] RECIP5        = 16'd13108;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_CHK,
    ST_FREE_RD,
    ST_COMMIT,
    ST_AL_OUT,
    ST_SW_RD,
    ST_SW_CHK,
    ST_SW_DIV,
    ST_SW_PUSH,
    ST_SW_END
  } state_t;

  typedef struct packed {
    logic       fe;
    logic       af;
    logic [7:0] tlev;
    logic       tapp;
    logic [7:0] elev;
    logic       eapp;
    cnt_t       evicted;
    slot_t      slot;
  } res_t;

endpackage

// File: design/aging_pool_allocator_with_fade_core.sv
// Aging pool allocator: 64 slots, LIFO free stack, age-ordered active list.
// Input channel (in_*): one request per item. in_tuser is the mode (0 allocate,
// 1 sweep); in_tdata carries now, alpha_fade and energy.
// Output channel (out_*): one result per allocate while enabled, one per surviving entry of
// a sweep; out_tlast marks the final result of a request.
// Config channel (cfg_*): index 0 enable, 1 lifetime, 2 fade_time; always ready.
// Requests are taken one at a time; in_tready is high only while idle.
// Allocate: evicts the oldest entries first when the pool is full.
// Sweep: walks the active entries from newest to oldest through the slot
// memories and runs the divider for each survivor in the fade window.
// Sweep results pass through a one-entry hold stage and an output register; a stalled
// receiver stops the walk only when both are full.
// Reset: empty list, every slot free in order 0..63, enable=1, lifetime=10000,
// fade_time=1000. No clearing pass; the free-link memory uses valid bits.
module aging_pool_allocator_with_fade_core import apa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,   // [0] mode
  input  logic [39:0]          in_tdata,   // [30:0] now, [31] alpha_fade, [32] energy
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // [5:0] slot, [12:6] evicted, [13] energy_applies,
                                           // [21:14] energy_level, [22] time_fade_applies,
                                           // [30:23] time_fade_level, [31] alpha_fade_flag,
                                           // [32] energy_flag
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TS_W-1:0]      cfg_data
);

  state_t state_r, state_nxt;

  logic  enable_r;
  ts_t   lifetime_r, fade_r;
  slot_t newest_r, newest_nxt, oldest_r, oldest_nxt, free_top_r, free_top_nxt;
  slot_t cur_r, cur_nxt, slot_r, slot_nxt;
  cnt_t  cnt_r, cnt_nxt, left_r, left_nxt, evict_r, evict_nxt;
  ts_t   now_r, t0_r, t0_nxt;
  logic  af_r, fe_r, first_r, first_nxt;
  logic  [POOL_SLOTS-1:0] fvld_r, fvld_nxt;
  logic  fv_q;
  res_t  hold_r, hold_nxt, out_r, out_nxt, cand;
  logic  hold_vld_r, hold_vld_nxt, out_vld_r, out_vld_nxt, out_last_r, out_last_nxt;
  logic  eapp_r, eapp_nxt, tapp_r, tapp_nxt, sfa_r, sfa_nxt, sfe_r, sfe_nxt;
  logic  [7:0] elev_r, elev_nxt;

  // memory ports
  logic  rd_en;
  slot_t rd_addr;
  ts_t   st_q;
  logic  [1:0] fl_q;
  slot_t ol_q, nw_q, fr_q;
  logic  st_we, fl_we, ol_we, nw_we, fr_we, fr_re;
  slot_t st_wa, ol_wa, nw_wa, fr_wa;
  slot_t ol_wd, nw_wd;

  // datapath
  logic  in_acc, out_free;
  logic  [31:0] end_t, t_rem, age;
  logic  expired, div_start, div_done;
  logic  [7:0] div_q, e_lvl;
  logic  e_app;
  logic  [13:0] e_x;
  logic  [27:0] e_prod;
  logic  [8:0]  e_ceil;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_tready;

  apa_ram #(.W(TS_W), .DEPTH(POOL_SLOTS)) u_stamp (
    .clk, .we(st_we), .waddr(st_wa), .wdata(now_r), .re(rd_en), .raddr(rd_addr),
    .rdata(st_q));
  apa_ram #(.W(2), .DEPTH(POOL_SLOTS)) u_flags (
    .clk, .we(fl_we), .waddr(st_wa), .wdata({fe_r, af_r}), .re(rd_en),
    .raddr(rd_addr), .rdata(fl_q));
  apa_ram #(.W(SLOT_W), .DEPTH(POOL_SLOTS)) u_older (
    .clk, .we(ol_we), .waddr(ol_wa), .wdata(ol_wd), .re(rd_en), .raddr(rd_addr),
    .rdata(ol_q));
  apa_ram #(.W(SLOT_W), .DEPTH(POOL_SLOTS)) u_newer (
    .clk, .we(nw_we), .waddr(nw_wa), .wdata(nw_wd), .re(rd_en), .raddr(rd_addr),
    .rdata(nw_q));
  apa_ram #(.W(SLOT_W), .DEPTH(POOL_SLOTS)) u_free (
    .clk, .we(fr_we), .waddr(fr_wa), .wdata(free_top_r), .re(fr_re),
    .raddr(free_top_r), .rdata(fr_q));

  apa_div u_div (
    .clk, .rst_n, .start(div_start), .num_t(t_rem[TS_W-1:0]), .den(fade_r),
    .done(div_done), .quot(div_q));

  // Expiry and fade arithmetic on the entry just read
  always_comb begin
    end_t   = {1'b0, st_q} + {1'b0, lifetime_r};
    expired = {1'b0, now_r} > end_t;
    t_rem   = end_t - {1'b0, now_r};
    age     = {1'b0, now_r} - {1'b0, st_q};
    e_x     = 14'(3 * age[11:0]) + 14'd19;
    e_prod  = 28'(e_x[13:2]) * 28'(RECIP5);
    e_ceil  = 9'(e_prod[27:16]);
    e_app   = fl_q[1] && !age[31] && (age > ENERGY_AGE_LO);
    e_lvl   = (age >= ENERGY_AGE_HI) ? 8'd0 : 8'(ENERGY_BASE - e_ceil);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && enable_r) begin
          if (in_tuser == MODE_ALLOC) begin
            state_nxt = (cnt_r == cnt_t'(POOL_SLOTS)) ? ST_EV_RD : ST_FREE_RD;
          end else begin
            state_nxt = (cnt_r == '0) ? ST_IDLE : ST_SW_RD;
          end
        end
      end
      ST_EV_RD:   state_nxt = ST_EV_CHK;
      ST_EV_CHK: begin
        if (cnt_r != '0 && (first_r || st_q == t0_r)) begin
          state_nxt = ST_EV_RD;
        end else begin
          state_nxt = ST_FREE_RD;
        end
      end
      ST_FREE_RD: state_nxt = ST_COMMIT;
      ST_COMMIT:  state_nxt = ST_AL_OUT;
      ST_AL_OUT:  state_nxt = out_free ? ST_IDLE : ST_AL_OUT;
      ST_SW_RD:   state_nxt = ST_SW_CHK;
      ST_SW_CHK: begin
        if (expired) begin
          state_nxt = (left_r == cnt_t'(1)) ? ST_SW_END : ST_SW_RD;
        end else if (t_rem < {1'b0, fade_r}) begin
          state_nxt = ST_SW_DIV;
        end else begin
          state_nxt = ST_SW_PUSH;
        end
      end
      ST_SW_DIV:  state_nxt = div_done ? ST_SW_PUSH : ST_SW_DIV;
      ST_SW_PUSH: begin
        if (!hold_vld_r || out_free) begin
          state_nxt = (left_r == '0) ? ST_SW_END : ST_SW_RD;
        end
      end
      ST_SW_END: begin
        if (!hold_vld_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: memory control and register updates
  always_comb begin
    rd_en = 1'b0; rd_addr = cur_r;
    st_we = 1'b0; fl_we = 1'b0; ol_we = 1'b0; nw_we = 1'b0; fr_we = 1'b0;
    fr_re = 1'b0;
    st_wa = free_top_r; ol_wa = ol_q; nw_wa = newest_r; fr_wa = cur_r;
    ol_wd = ol_q; nw_wd = nw_q;
    div_start = 1'b0;
    newest_nxt = newest_r; oldest_nxt = oldest_r; free_top_nxt = free_top_r;
    cur_nxt = cur_r; slot_nxt = slot_r; cnt_nxt = cnt_r; left_nxt = left_r;
    evict_nxt = evict_r; t0_nxt = t0_r; first_nxt = first_r; fvld_nxt = fvld_r;
    eapp_nxt = eapp_r; elev_nxt = elev_r; tapp_nxt = tapp_r;
    sfa_nxt = sfa_r; sfe_nxt = sfe_r;
    hold_nxt = hold_r; hold_vld_nxt = hold_vld_r;
    out_nxt = out_r; out_last_nxt = out_last_r;
    out_vld_nxt = out_vld_r && !out_tready;

    cand         = '0;
    cand.slot    = slot_r;
    cand.eapp    = eapp_r;
    cand.elev    = elev_r;
    cand.tapp    = tapp_r;
    cand.tlev    = (state_r == ST_SW_DIV) ? div_q : 8'd0;
    cand.af      = sfa_r;
    cand.fe      = sfe_r;

    unique case (state_r)
      ST_IDLE: begin
        evict_nxt = '0;
        first_nxt = 1'b1;
        cur_nxt   = newest_r;
        left_nxt  = cnt_r;
      end
      ST_EV_RD: begin
        rd_en = 1'b1; rd_addr = oldest_r;
      end
      ST_EV_CHK: begin
        if (first_r) begin
          t0_nxt = st_q;
        end
        first_nxt = 1'b0;
        if (cnt_r != '0 && (first_r || st_q == t0_r)) begin
          // drop the oldest entry onto the free stack
          oldest_nxt = nw_q;
          if (oldest_r == newest_r) begin
            newest_nxt = ol_q;
          end else begin
            ol_we = 1'b1; ol_wa = nw_q; ol_wd = ol_q;
          end
          fr_we = 1'b1; fr_wa = oldest_r;
          fvld_nxt[oldest_r] = 1'b1;
          free_top_nxt = oldest_r;
          cnt_nxt   = cnt_r - cnt_t'(1);
          evict_nxt = evict_r + cnt_t'(1);
        end
      end
      ST_FREE_RD: begin
        fr_re = 1'b1;
      end
      ST_COMMIT: begin
        free_top_nxt = fv_q ? fr_q : slot_t'(free_top_r + slot_t'(1));
        st_we = 1'b1; fl_we = 1'b1; st_wa = free_top_r;
        if (cnt_r == '0) begin
          oldest_nxt = free_top_r;
        end else begin
          nw_we = 1'b1; nw_wa = newest_r; nw_wd = free_top_r;
        end
        ol_we = 1'b1; ol_wa = free_top_r; ol_wd = newest_r;
        newest_nxt = free_top_r;
        cnt_nxt    = cnt_r + cnt_t'(1);
      end
      ST_AL_OUT: begin
        if (out_free) begin
          out_nxt         = '0;
          out_nxt.slot    = newest_r;
          out_nxt.evicted = evict_r;
          out_nxt.af      = af_r;
          out_nxt.fe      = fe_r;
          out_last_nxt    = 1'b1;
          out_vld_nxt     = 1'b1;
        end
      end
      ST_SW_RD: begin
        rd_en = 1'b1; rd_addr = cur_r;
      end
      ST_SW_CHK: begin
        cur_nxt  = ol_q;
        left_nxt = left_r - cnt_t'(1);
        slot_nxt = cur_r;
        sfa_nxt  = fl_q[0];
        sfe_nxt  = fl_q[1];
        eapp_nxt = e_app;
        elev_nxt = e_app ? e_lvl : 8'd0;
        tapp_nxt = t_rem < {1'b0, fade_r};
        if (expired) begin
          if (cur_r == newest_r) begin
            newest_nxt = ol_q;
          end else begin
            ol_we = 1'b1; ol_wa = nw_q; ol_wd = ol_q;
          end
          if (cur_r == oldest_r) begin
            oldest_nxt = nw_q;
          end else begin
            nw_we = 1'b1; nw_wa = ol_q; nw_wd = nw_q;
          end
          fr_we = 1'b1; fr_wa = cur_r;
          fvld_nxt[cur_r] = 1'b1;
          free_top_nxt = cur_r;
          cnt_nxt = cnt_r - cnt_t'(1);
        end else if (t_rem < {1'b0, fade_r}) begin
          div_start = 1'b1;
        end
      end
      ST_SW_DIV: begin
        // latch the quotient in the hold path via PUSH
        if (div_done) begin
          hold_nxt = hold_r;
          elev_nxt = elev_r;
        end
      end
      ST_SW_PUSH: begin
        if (!hold_vld_r || out_free) begin
          if (hold_vld_r) begin
            out_nxt      = hold_r;
            out_last_nxt = 1'b0;
            out_vld_nxt  = 1'b1;
          end
          hold_nxt      = cand;
          hold_nxt.tlev = tapp_r ? div_q : 8'd0;
          hold_vld_nxt  = 1'b1;
        end
      end
      ST_SW_END: begin
        if (hold_vld_r && out_free) begin
          out_nxt      = hold_r;
          out_last_nxt = 1'b1;
          out_vld_nxt  = 1'b1;
          hold_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      enable_r   <= 1'b1;
      lifetime_r <= ts_t'(10000);
      fade_r     <= ts_t'(1000);
      newest_r   <= '0;
      oldest_r   <= '0;
      free_top_r <= '0;
      cnt_r      <= '0;
      fvld_r     <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      newest_r   <= newest_nxt;
      oldest_r   <= oldest_nxt;
      free_top_r <= free_top_nxt;
      cnt_r      <= cnt_nxt;
      fvld_r     <= fvld_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ENABLE:   enable_r   <= cfg_data[0];
          CFG_LIFETIME: lifetime_r <= cfg_data;
          CFG_FADE:     fade_r     <= cfg_data;
          default: ;
        endcase
      end
    end
    if (in_acc) begin
      now_r <= in_tdata[TS_W-1:0];
      af_r  <= in_tdata[TS_W];
      fe_r  <= in_tdata[TS_W+1];
    end
    fv_q       <= fvld_r[free_top_r];
    cur_r      <= cur_nxt;
    slot_r     <= slot_nxt;
    left_r     <= left_nxt;
    evict_r    <= evict_nxt;
    t0_r       <= t0_nxt;
    first_r    <= first_nxt;
    eapp_r     <= eapp_nxt;
    elev_r     <= elev_nxt;
    tapp_r     <= tapp_nxt;
    sfa_r      <= sfa_nxt;
    sfe_r      <= sfe_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_r};

endmodule

// File: design/apa_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module apa_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/apa_div.sv
// Restoring divider for the time fade: quot = floor(255*t / den), t < den.
// Depends on apa_pkg; one quotient bit per cycle.
module apa_div import apa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  ts_t        num_t,
  input  ts_t        den,
  output logic       done,
  output logic [7:0] quot
);

  logic [TS_W+7:0] rem_r, rem_nxt;
  ts_t             den_r;
  logic [2:0]      step_r, step_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [7:0]      q_r, q_nxt;
  logic [TS_W+7:0] trial;

  always_comb begin
    trial    = {8'd0, den_r} << step_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {num_t, 8'd0} - {8'd0, num_t};
      q_nxt    = '0;
      step_nxt = 3'd7;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt        = rem_r - trial;
        q_nxt[step_r]  = 1'b1;
      end
      step_nxt = step_r - 3'd1;
      if (step_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: design/apa_checker.sv
// Port-level checks for the aging pool allocator core.
// Depends on assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module apa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tlast,
  input logic [39:0] out_tdata
);

  `AP_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `AP_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `AP_ASSERT_NOW(a_sweep_no_evict, clk, rst_n, out_tvalid && !out_tlast,
                 out_tdata[12:6] == 7'd0)
  `AP_ASSERT_NOW(a_elev_zero, clk, rst_n, out_tvalid && !out_tdata[13],
                 out_tdata[21:14] == 8'd0)

endmodule

bind aging_pool_allocator_with_fade_core apa_checker u_apa_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tlast(out_tlast), .out_tdata(out_tdata));
